/* sv/button_debounce_long_press_unit_assert.svh */
// Assertion macros used by the debounce unit's top-level RTL file.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_UNIT_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDLP_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("bdlp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BDLP_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("bdlp assertion failed");

`endif

/* sv/bdlp_pkg.sv */
// Package: sizes, register map, payload, config and status types, wrap-around timing helper.
package bdlp_pkg;

	localparam int NUM_BUTTONS = 4;
	localparam int TIME_BITS   = 32;

	localparam int NUM_REGS = 5;
	localparam int ADDR_W   = $clog2(NUM_REGS * 4);
	localparam int DATA_W   = 32;
	localparam int IDX_W    = ADDR_W - 2;

	localparam logic [IDX_W-1:0] REG_ENABLE_MASK   = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_ACTIVE_LOW    = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_DEBOUNCE_MS   = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_LONG_PRESS_MS = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_COMBO_HOLD_MS = IDX_W'(4);

	localparam logic [9:0]  DEBOUNCE_RST   = 10'd30;
	localparam logic [15:0] LONG_PRESS_RST = 16'd2000;
	localparam logic [15:0] COMBO_HOLD_RST = 16'd5000;

	typedef logic [TIME_BITS-1:0] time_t;

	typedef struct packed {
		logic [NUM_BUTTONS-1:0] raw_levels;
		time_t                  time_ms;
	} poll_t;

	typedef struct packed {
		logic [NUM_BUTTONS-1:0] short_press_mask;
		logic [NUM_BUTTONS-1:0] long_press_mask;
		logic                   reset_request;
		logic [NUM_BUTTONS-1:0] pressed_mask;
	} result_t;

	typedef struct packed {
		logic [NUM_BUTTONS-1:0] enable_mask;
		logic                   active_low;
		logic [9:0]             debounce_ms;
		logic [15:0]            long_press_ms;
		logic [15:0]            combo_hold_ms;
	} cfg_t;

	typedef struct packed {
		logic stable;
		logic short_ev;
		logic long_ev;
	} lane_stat_t;

	function automatic time_t elapsed(input time_t tnow, input time_t then);
		return tnow - then;
	endfunction

endpackage

/* sv/button_debounce_long_press_unit.sv */
// Top level: button debouncer with short, long press and two-button reset combo.
// Each poll beat (raw pin levels plus a millisecond timestamp) yields exactly one
// result beat. A poll is taken every clock cycle while the result register is free
// or being drained, and its result is registered in the output register on
// acceptance. Four button lanes update their state in the cycle of acceptance; the
// throughput of one poll per cycle rests on that state update being computed
// combinationally (a 32-bit wrap-around subtract and compare against the debounce
// and long-press times in each lane, then the combo compare in the merge stage).
// Configuration is written through the APB port, one register per word address,
// by the user only while no poll is in flight; the block does not enforce this.
module button_debounce_long_press_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  bdlp_pkg::poll_t             req_data,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output bdlp_pkg::result_t           rsp_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bdlp_pkg::ADDR_W-1:0] paddr,
	input  logic [bdlp_pkg::DATA_W-1:0] pwdata,
	output logic [bdlp_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import bdlp_pkg::*;

	`include "button_debounce_long_press_unit_assert.svh"

	cfg_t       cfg;
	lane_stat_t stat [NUM_BUTTONS];
	logic [1:0] force_long;
	result_t    res;
	result_t    rsp_data_q;
	logic       rsp_valid_q;
	logic       accept;
	logic [NUM_BUTTONS-1:0] down;
	logic [NUM_BUTTONS-1:0] short_held, long_free;
	logic       combo_req;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign down      = cfg.active_low ? ~req_data.raw_levels : req_data.raw_levels;

	bdlp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	for (genvar k = 0; k < NUM_BUTTONS; k++) begin : g_lane
		logic frc;
		if (k < 2) begin : g_combo
			assign frc = force_long[k];
		end else begin : g_plain
			assign frc = 1'b0;
		end
		bdlp_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.upd        (accept),
			.en         (cfg.enable_mask[k]),
			.down       (down[k]),
			.tnow       (req_data.time_ms),
			.cfg        (cfg),
			.force_long (frc),
			.stat       (stat[k])
		);
	end

	bdlp_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (accept),
		.tnow       (req_data.time_ms),
		.cfg        (cfg),
		.stat       (stat),
		.force_long (force_long),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// payload register: load on every accepted poll
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_data_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	assign short_held = rsp_data_q.short_press_mask & rsp_data_q.pressed_mask;
	assign long_free  = rsp_data_q.long_press_mask & ~rsp_data_q.pressed_mask;
	assign combo_req  = rsp_valid_q && rsp_data_q.reset_request;

	`BDLP_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !rsp_valid_q, req_ready)
	`BDLP_ASSERT_NEXT(a_accept_loads, clk, arst_n, accept, rsp_valid_q)
	`BDLP_ASSERT_NOW(a_short_released, clk, arst_n, rsp_valid_q, short_held == '0)
	`BDLP_ASSERT_NOW(a_long_held, clk, arst_n, rsp_valid_q, long_free == '0)
	`BDLP_ASSERT_NOW(a_combo_held, clk, arst_n, combo_req, rsp_data_q.pressed_mask[1:0] == 2'b11)

endmodule

/* sv/bdlp_regs.sv */
// APB configuration registers of the debounce unit.
module bdlp_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [bdlp_pkg::ADDR_W-1:0] paddr,
	input  logic [bdlp_pkg::DATA_W-1:0] pwdata,
	output logic [bdlp_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	output bdlp_pkg::cfg_t            cfg
);
	import bdlp_pkg::*;

	cfg_t             cfg_q;
	logic [IDX_W-1:0] idx;
	logic             wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_mask   <= '1;
			cfg_q.active_low    <= 1'b1;
			cfg_q.debounce_ms   <= DEBOUNCE_RST;
			cfg_q.long_press_ms <= LONG_PRESS_RST;
			cfg_q.combo_hold_ms <= COMBO_HOLD_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_ENABLE_MASK:   cfg_q.enable_mask   <= pwdata[NUM_BUTTONS-1:0];
				REG_ACTIVE_LOW:    cfg_q.active_low    <= pwdata[0];
				REG_DEBOUNCE_MS:   cfg_q.debounce_ms   <= pwdata[9:0];
				REG_LONG_PRESS_MS: cfg_q.long_press_ms <= pwdata[15:0];
				REG_COMBO_HOLD_MS: cfg_q.combo_hold_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ENABLE_MASK:   prdata = DATA_W'(cfg_q.enable_mask);
			REG_ACTIVE_LOW:    prdata = DATA_W'(cfg_q.active_low);
			REG_DEBOUNCE_MS:   prdata = DATA_W'(cfg_q.debounce_ms);
			REG_LONG_PRESS_MS: prdata = DATA_W'(cfg_q.long_press_ms);
			REG_COMBO_HOLD_MS: prdata = DATA_W'(cfg_q.combo_hold_ms);
			default:           prdata = '0;
		endcase
	end

endmodule

/* sv/bdlp_lane.sv */
// One button lane: release qualification, debounce, short and long press detection.
module bdlp_lane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 upd,
	input  logic                 en,
	input  logic                 down,
	input  bdlp_pkg::time_t      tnow,
	input  bdlp_pkg::cfg_t       cfg,
	input  logic                 force_long,
	output bdlp_pkg::lane_stat_t stat
);
	import bdlp_pkg::*;

	logic  ignore_q, raw_last_q, stable_q, long_done_q, timing_q;
	time_t chg_time_q, start_time_q;

	logic  ignore_n, raw_last_n, stable_n, long_done_n, timing_n;
	time_t chg_time_n, start_time_n;
	logic  short_ev, long_ev;

	always_comb begin
		ignore_n     = ignore_q;
		raw_last_n   = raw_last_q;
		stable_n     = stable_q;
		long_done_n  = long_done_q;
		timing_n     = timing_q;
		chg_time_n   = chg_time_q;
		start_time_n = start_time_q;
		short_ev     = 1'b0;
		long_ev      = 1'b0;
		if (en) begin
			if (ignore_q) begin
				// wait for the first release after reset
				if (!down) begin
					ignore_n   = 1'b0;
					raw_last_n = 1'b0;
					stable_n   = 1'b0;
					chg_time_n = tnow;
				end
			end else begin
				if (down != raw_last_q) begin
					raw_last_n = down;
					chg_time_n = tnow;
				end
				if (elapsed(tnow, chg_time_n) >= TIME_BITS'(cfg.debounce_ms)) begin
					if (down != stable_q) begin
						stable_n    = down;
						long_done_n = 1'b0;
						if (down) begin
							start_time_n = tnow;
							timing_n     = 1'b1;
						end else begin
							short_ev     = !long_done_q;
							timing_n     = 1'b0;
							start_time_n = '0;
						end
					end
					if (stable_n && !long_done_n && timing_n &&
					    elapsed(tnow, start_time_n) >= TIME_BITS'(cfg.long_press_ms)) begin
						long_done_n = 1'b1;
						long_ev     = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_q     <= 1'b1;
			raw_last_q   <= 1'b0;
			stable_q     <= 1'b0;
			long_done_q  <= 1'b0;
			timing_q     <= 1'b0;
			chg_time_q   <= '0;
			start_time_q <= '0;
		end else if (upd) begin
			ignore_q     <= ignore_n;
			raw_last_q   <= raw_last_n;
			stable_q     <= stable_n;
			long_done_q  <= long_done_n | force_long;
			timing_q     <= timing_n;
			chg_time_q   <= chg_time_n;
			start_time_q <= start_time_n;
		end
	end

	assign stat.stable   = stable_n;
	assign stat.short_ev = short_ev;
	assign stat.long_ev  = long_ev;

endmodule

/* sv/bdlp_merge.sv */
// Merge stage: gathers lane events, tracks the buttons 0+1 combo, builds the result.
module bdlp_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 upd,
	input  bdlp_pkg::time_t      tnow,
	input  bdlp_pkg::cfg_t       cfg,
	input  bdlp_pkg::lane_stat_t stat [bdlp_pkg::NUM_BUTTONS],
	output logic [1:0]           force_long,
	output bdlp_pkg::result_t    res
);
	import bdlp_pkg::*;

	logic  active_q, fired_q;
	time_t start_q;

	logic  active_n, fired_n;
	time_t start_n;
	logic  both, req;
	logic [NUM_BUTTONS-1:0] stable_v, short_v, long_v;

	always_comb begin
		for (int k = 0; k < NUM_BUTTONS; k++) begin
			stable_v[k] = stat[k].stable;
			short_v[k]  = stat[k].short_ev;
			long_v[k]   = stat[k].long_ev;
		end
	end

	always_comb begin
		both     = (cfg.enable_mask[1:0] == 2'b11) && stable_v[0] && stable_v[1];
		active_n = active_q;
		fired_n  = fired_q;
		start_n  = start_q;
		req      = 1'b0;
		if (both && !active_q) begin
			active_n = 1'b1;
			fired_n  = 1'b0;
			start_n  = tnow;
		end else if (!both) begin
			active_n = 1'b0;
			fired_n  = 1'b0;
			start_n  = '0;
		end
		if (active_n && !fired_n &&
		    elapsed(tnow, start_n) >= TIME_BITS'(cfg.combo_hold_ms)) begin
			fired_n = 1'b1;
			req     = 1'b1;
		end
	end

	// mute further events of buttons 0 and 1 once the combo forms
	assign force_long = {2{both && !active_q}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			fired_q  <= 1'b0;
			start_q  <= '0;
		end else if (upd) begin
			active_q <= active_n;
			fired_q  <= fired_n;
			start_q  <= start_n;
		end
	end

	assign res.short_press_mask = short_v;
	assign res.long_press_mask  = long_v;
	assign res.reset_request    = req;
	assign res.pressed_mask     = stable_v & cfg.enable_mask;

endmodule
